FILE: src/ciir_pkg.sv
package ciir_pkg;

  // item opcodes
  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic CFG_SECTION_COUNT = 1'b0;
  localparam logic CFG_FOURTH_ORDER  = 1'b1;

  localparam int WORDS_PER_SECTION = 9;
  localparam int HIST_DEPTH        = 4;
  localparam int COEF_W            = 32;
  localparam int SAMPLE_W          = 24;
  localparam int ACC_W             = 72;
  localparam int ROUND_SHIFT       = 28;

  typedef logic [HIST_DEPTH-1:0][COEF_W-1:0]   hist_row_t;
  typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] in_hist_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_MAC,
    ST_DRAIN,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

FILE: src/cascaded_iir_section_filter_top.sv
// channel  direction  handshake               payload
// in       input      in_valid / in_stall     opcode, sample_in, coef_section, coef_slot,
//                                             coef_value
// out      output     out_valid / out_stall   sample_out, saturated
// cfg      input      cfg_write               cfg_index, cfg_data
//
// A filter request takes, per section in use, one history read, 2*order+1
// multiplier issues, a pipeline drain and one round/write step, plus one
// output load step at the end. All multiplies go through the single 32x32 MAC.
// Write and clear requests take effect when accepted, without leaving idle.
// Reset clears the history row valid bits and input history. in_stall is high
// while a filter request runs; a finished result waits in the output register
// while the next is accepted.
module cascaded_iir_section_filter_top #(
  parameter int NUM_SECTIONS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic signed [ciir_pkg::SAMPLE_W-1:0] sample_in,
  input  logic [2:0]  coef_section,
  input  logic [3:0]  coef_slot,
  input  logic signed [ciir_pkg::COEF_W-1:0] coef_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [ciir_pkg::SAMPLE_W-1:0] sample_out,
  output logic        saturated,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  import ciir_pkg::*;

  localparam int SEC_W   = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
  localparam int COEF_N  = NUM_SECTIONS * WORDS_PER_SECTION;
  localparam int CA_W    = $clog2(COEF_N);

  state_t state, state_next;

  logic [3:0]  section_count;
  logic        fourth_order_mode;

  logic [COEF_W-1:0] coef_mem [COEF_N];
  hist_row_t         hist_mem [NUM_SECTIONS];
  logic [NUM_SECTIONS-1:0] row_valid;

  in_hist_t   in_hist;
  hist_row_t  prev_row;
  hist_row_t  hist_q;
  logic       row_valid_q;
  hist_row_t  yrow;
  hist_row_t  row_new;

  logic [SEC_W-1:0] sec, last_sec;
  logic [3:0]  term, last_term;
  logic signed [COEF_W-1:0] cur_x;
  logic signed [SAMPLE_W-1:0] x_in;

  logic signed [COEF_W-1:0] coef_q, op_q;
  logic signed [2*COEF_W-1:0] prod;
  logic        v1, v2;
  logic signed [ACC_W-1:0] acc;
  logic        sat_acc;

  logic        in_accept;
  logic        start_filter;
  logic        last_issue;
  logic        pipe_empty;
  logic        out_free;
  logic        is_last_sec;

  logic [5:0]  n_sec;
  logic [2:0]  half;
  logic [1:0]  tap;
  logic [3:0]  slot;
  logic [CA_W-1:0] coef_rd_addr, coef_wr_addr;
  logic signed [COEF_W-1:0] operand;

  logic signed [ACC_W-1:0] acc_round;
  logic signed [ACC_W-ROUND_SHIFT-1:0] acc_shift;
  logic signed [COEF_W-1:0] y_sat;
  logic        y_clip;
  logic signed [SAMPLE_W-1:0] res_sat;
  logic        res_clip;

  assign in_accept    = in_valid && !in_stall;
  assign start_filter = in_accept && (opcode == OP_FILTER);
  assign last_issue   = (term == last_term);
  assign pipe_empty   = !v1 && !v2;
  assign out_free     = !out_valid || !out_stall;
  assign is_last_sec  = (sec == last_sec);

  // clamp the section count to 1..NUM_SECTIONS
  always_comb begin
    if (section_count == 4'd0) begin
      n_sec = 6'd1;
    end else if ({2'b00, section_count} > 6'(NUM_SECTIONS)) begin
      n_sec = 6'(NUM_SECTIONS);
    end else begin
      n_sec = {2'b00, section_count};
    end
  end

  // term 0: b0*x; odd terms: b_k*xh[k-1]; even terms: a_k*yh[k-1]
  assign half = term[3:1];
  assign tap  = term[0] ? half[1:0] : 2'(half - 3'd1);
  assign yrow = row_valid_q ? hist_q : '0;

  always_comb begin
    if (term == 4'd0) begin
      slot    = 4'd0;
      operand = cur_x;
    end else if (term[0]) begin
      slot    = {1'b0, half} + 4'd1;
      operand = prev_row[tap];
    end else begin
      slot    = {1'b0, half} + 4'd4;
      operand = yrow[tap];
    end
  end

  assign coef_rd_addr = CA_W'({sec, 3'b000}) + CA_W'(sec) + CA_W'(slot);
  assign coef_wr_addr = CA_W'({coef_section, 3'b000}) + CA_W'(coef_section)
                      + CA_W'(coef_slot);

  // round half up to Q.23, then clip to 32 bits
  assign acc_round = acc + ACC_W'(64'sd1 <<< (ROUND_SHIFT - 1));
  assign acc_shift = acc_round[ACC_W-1:ROUND_SHIFT];

  always_comb begin
    y_clip = (acc_shift[ACC_W-ROUND_SHIFT-1:COEF_W-1] != '0)
          && (acc_shift[ACC_W-ROUND_SHIFT-1:COEF_W-1] != '1);
    if (!y_clip) begin
      y_sat = acc_shift[COEF_W-1:0];
    end else if (acc_shift[ACC_W-ROUND_SHIFT-1]) begin
      y_sat = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  always_comb begin
    res_clip = (cur_x[COEF_W-1:SAMPLE_W-1] != '0) && (cur_x[COEF_W-1:SAMPLE_W-1] != '1);
    if (!res_clip) begin
      res_sat = cur_x[SAMPLE_W-1:0];
    end else if (cur_x[COEF_W-1]) begin
      res_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_comb begin
    row_new    = '0;
    row_new[0] = y_sat;
    for (int i = 1; i < HIST_DEPTH; i++) begin
      row_new[i] = yrow[i-1];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_filter) state_next = ST_ROW;
      ST_ROW:   state_next = ST_MAC;
      ST_MAC:   if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: if (pipe_empty) state_next = ST_FIN;
      ST_FIN:   state_next = is_last_sec ? ST_OUT : ST_ROW;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section_count     <= 4'd1;
      fourth_order_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SECTION_COUNT: section_count     <= cfg_data;
        CFG_FOURTH_ORDER:  fourth_order_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (in_accept && (opcode == OP_WRITE) && (coef_slot < 4'(WORDS_PER_SECTION))
        && (6'(coef_section) < 6'(NUM_SECTIONS))) begin
      coef_mem[coef_wr_addr] <= coef_value;
    end
    coef_q <= coef_mem[coef_rd_addr];
  end

  // section history memory, one row per section
  always_ff @(posedge clk) begin
    if (state == ST_FIN) begin
      hist_mem[sec] <= row_new;
    end
    if (state == ST_ROW) begin
      hist_q <= hist_mem[sec];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      in_hist   <= '0;
    end else if (in_accept && (opcode == OP_CLEAR)) begin
      row_valid <= '0;
      in_hist   <= '0;
    end else if (state == ST_FIN) begin
      row_valid[sec] <= 1'b1;
      if (is_last_sec) begin
        in_hist <= {in_hist[HIST_DEPTH-2:0], x_in};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_MAC);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    op_q <= operand;
    prod <= coef_q * op_q;
    if (state == ST_ROW) begin
      row_valid_q <= row_valid[sec];
      acc         <= '0;
      term        <= 4'd0;
    end else begin
      if (state == ST_MAC) begin
        term <= term + 4'd1;
      end
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (start_filter) begin
      sec       <= '0;
      last_sec  <= SEC_W'(n_sec - 6'd1);
      last_term <= fourth_order_mode ? 4'd8 : 4'd4;
      x_in      <= sample_in;
      cur_x     <= COEF_W'(sample_in);
      sat_acc   <= 1'b0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        prev_row[i] <= COEF_W'($signed(in_hist[i]));
      end
    end else if (state == ST_FIN) begin
      cur_x    <= y_sat;
      sat_acc  <= sat_acc | y_clip;
      prev_row <= yrow;
      if (!is_last_sec) begin
        sec <= sec + SEC_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_OUT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_OUT) && out_free) begin
      sample_out <= res_sat;
      saturated  <= sat_acc | res_clip;
    end
  end

endmodule
